// ===== rtl/core/whps_pkg.sv =====
`timescale 1ns / 1ps

package whps_pkg;

    // Field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned NODE_W    = 8;
    localparam int unsigned READING_W = 16;
    localparam int unsigned WID_W     = 3;
    localparam int unsigned NUM_WARN  = 4;

    // Stream widths: fields packed from bit 0, padded to whole bytes
    localparam int unsigned ITEM_BITS   = 95;
    localparam int unsigned S_TDATA_W   = 96;
    localparam int unsigned RESULT_BITS = WID_W + NUM_WARN;
    localparam int unsigned M_TDATA_W   = 8;

    // Configuration port
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REV_ON    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_ON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_OFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAN_ON   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAN_OFF  = 3'd7;

    // Warning slots, highest priority first
    localparam int unsigned W_FAULT = 0;
    localparam int unsigned W_REV   = 1;
    localparam int unsigned W_BOOST = 2;
    localparam int unsigned W_LEAN  = 3;

    // Warning codes on the result
    localparam logic [WID_W-1:0] WID_NONE  = 3'd0;
    localparam logic [WID_W-1:0] WID_FAULT = 3'd1;
    localparam logic [WID_W-1:0] WID_REV   = 3'd2;
    localparam logic [WID_W-1:0] WID_BOOST = 3'd3;
    localparam logic [WID_W-1:0] WID_LEAN  = 3'd4;

    localparam logic [TIME_W-1:0] HOLD_MS        = 32'd2000;
    localparam logic [NODE_W-1:0] SHARED_NODE_ID = 8'd0;

    // Input request; the last member sits in the lowest bits
    typedef struct packed {
        logic                        page_shows_afr;
        logic                        page_shows_map;
        logic                        page_shows_rpm;
        logic signed [READING_W-1:0] afr_value;
        logic                        afr_ok;
        logic signed [READING_W-1:0] map_value;
        logic                        map_ok;
        logic signed [READING_W-1:0] rpm_value;
        logic                        rpm_ok;
        logic                        fault_active;
        logic [NODE_W-1:0]           node_id;
        logic [TIME_W-1:0]           now_ms;
    } t_item;

    typedef struct packed {
        logic [NUM_WARN-1:0] active_mask;
        logic [WID_W-1:0]    warning_id;
    } t_result;

    // Hysteresis comparator: a missing reading clears the latch
    function automatic logic hyst(
        input logic                        was,
        input logic                        have,
        input logic signed [READING_W-1:0] val,
        input logic signed [CFG_W-1:0]     on_lv,
        input logic signed [CFG_W-1:0]     off_lv
    );
        logic res;
        if (!have) begin
            res = 1'b0;
        end else if (was) begin
            res = (val >= off_lv);
        end else begin
            res = (val >= on_lv);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/warning_hysteresis_priority_select_top.sv =====
`timescale 1ns / 1ps

// Warning selector for a dashboard display node.
//
// Slave stream (i_s_*): one engine update request per handshake, carrying the
// time stamp, three readings with their fresh flags, the fault flag, the node
// id and the page visibility flags. Master stream (o_m_*): one result request
// per update, giving the warning to show and the latch states after the update.
// Configuration: write i_cfg_data into threshold i_cfg_index while i_cfg_wr_en
// is high; write only while no update is in flight.
//
// The latches, hold deadlines and result register all load on the edge that
// accepts the update. Throughput is one update per cycle while the master
// keeps taking results, set by the single result register. o_s_tready stays
// high while the result register is empty or being taken, so a stalled master
// holds the current result and keeps o_s_tready low until that result is taken.
//
// Synchronous active-low reset clears the thresholds, all latches and the hold
// deadlines to zero and empties the result register. Note that a deadline of
// zero means a warning that never fired counts as held while now_ms has bit 31
// set.
module warning_hysteresis_priority_select_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // bits from 0: now_ms[31:0], node_id[39:32], fault_active[40], rpm_ok[41],
    // rpm_value[57:42], map_ok[58], map_value[74:59], afr_ok[75],
    // afr_value[91:76], page_shows_rpm[92], page_shows_map[93],
    // page_shows_afr[94], zero pad[95]
    input  logic [whps_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // bits from 0: warning_id[2:0], active_mask[6:3], zero pad[7]
    output logic [whps_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // configuration writes
    input  logic                              i_cfg_wr_en,
    input  logic [whps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [whps_pkg::CFG_W-1:0]        i_cfg_data
);

    whps_pkg::t_item   w_item;
    whps_pkg::t_result n_result;
    whps_pkg::t_result r_result;

    logic signed [whps_pkg::CFG_W-1:0] r_cfg [whps_pkg::NUM_CFG];

    logic [whps_pkg::NUM_WARN-1:0] r_warn_on;
    logic [whps_pkg::NUM_WARN-1:0] n_warn_on;
    logic                          r_load_latched;
    logic                          n_load_latched;
    logic [whps_pkg::TIME_W-1:0]   r_deadline [whps_pkg::NUM_WARN];
    logic [whps_pkg::TIME_W-1:0]   n_deadline [whps_pkg::NUM_WARN];
    logic [whps_pkg::NUM_WARN-1:0] w_held;
    logic [whps_pkg::NUM_WARN-1:0] w_shows;
    logic [whps_pkg::TIME_W-1:0]   w_fire_deadline;
    logic                          r_out_valid;
    logic                          w_accept;

    assign w_item     = whps_pkg::t_item'(i_s_tdata[whps_pkg::ITEM_BITS-1:0]);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < whps_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // latch update and priority pick, all from the incoming request
    always_comb begin
        n_warn_on[whps_pkg::W_FAULT] = w_item.fault_active;
        n_warn_on[whps_pkg::W_REV]   = whps_pkg::hyst(
            r_warn_on[whps_pkg::W_REV], w_item.rpm_ok, w_item.rpm_value,
            r_cfg[whps_pkg::CFG_REV_ON], r_cfg[whps_pkg::CFG_REV_OFF]);
        n_warn_on[whps_pkg::W_BOOST] = whps_pkg::hyst(
            r_warn_on[whps_pkg::W_BOOST], w_item.map_ok, w_item.map_value,
            r_cfg[whps_pkg::CFG_BOOST_ON], r_cfg[whps_pkg::CFG_BOOST_OFF]);
        n_load_latched = whps_pkg::hyst(
            r_load_latched, w_item.map_ok, w_item.map_value,
            r_cfg[whps_pkg::CFG_LOAD_ON], r_cfg[whps_pkg::CFG_LOAD_OFF]);
        // lean only counts under load
        n_warn_on[whps_pkg::W_LEAN] = n_load_latched && whps_pkg::hyst(
            r_warn_on[whps_pkg::W_LEAN], w_item.afr_ok, w_item.afr_value,
            r_cfg[whps_pkg::CFG_LEAN_ON], r_cfg[whps_pkg::CFG_LEAN_OFF]);

        w_fire_deadline = w_item.now_ms + whps_pkg::HOLD_MS;

        w_shows[whps_pkg::W_FAULT] = (w_item.node_id == whps_pkg::SHARED_NODE_ID);
        w_shows[whps_pkg::W_REV]   = w_item.page_shows_rpm;
        w_shows[whps_pkg::W_BOOST] = w_item.page_shows_map;
        w_shows[whps_pkg::W_LEAN]  = w_item.page_shows_afr;

        for (int i = 0; i < whps_pkg::NUM_WARN; i++) begin
            // rising edge restarts the hold-over
            if (n_warn_on[i] && !r_warn_on[i]) begin
                n_deadline[i] = w_fire_deadline;
            end else begin
                n_deadline[i] = r_deadline[i];
            end
            w_held[i] = w_item.now_ms[whps_pkg::TIME_W-1] ^ n_deadline[i][whps_pkg::TIME_W-1]
                ? ((w_item.now_ms - n_deadline[i]) >> (whps_pkg::TIME_W-1)) != '0
                : ((w_item.now_ms - n_deadline[i]) >> (whps_pkg::TIME_W-1)) != '0;
        end

        n_result.active_mask = n_warn_on;
        if ((n_warn_on[whps_pkg::W_FAULT] || w_held[whps_pkg::W_FAULT])
                && w_shows[whps_pkg::W_FAULT]) begin
            n_result.warning_id = whps_pkg::WID_FAULT;
        end else if ((n_warn_on[whps_pkg::W_REV] || w_held[whps_pkg::W_REV])
                && w_shows[whps_pkg::W_REV]) begin
            n_result.warning_id = whps_pkg::WID_REV;
        end else if ((n_warn_on[whps_pkg::W_BOOST] || w_held[whps_pkg::W_BOOST])
                && w_shows[whps_pkg::W_BOOST]) begin
            n_result.warning_id = whps_pkg::WID_BOOST;
        end else if ((n_warn_on[whps_pkg::W_LEAN] || w_held[whps_pkg::W_LEAN])
                && w_shows[whps_pkg::W_LEAN]) begin
            n_result.warning_id = whps_pkg::WID_LEAN;
        end else begin
            n_result.warning_id = whps_pkg::WID_NONE;
        end
    end

    // state advances only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_on      <= '0;
            r_load_latched <= 1'b0;
            for (int i = 0; i < whps_pkg::NUM_WARN; i++) begin
                r_deadline[i] <= '0;
            end
        end else if (w_accept) begin
            r_warn_on      <= n_warn_on;
            r_load_latched <= n_load_latched;
            for (int i = 0; i < whps_pkg::NUM_WARN; i++) begin
                r_deadline[i] <= n_deadline[i];
            end
        end
    end

    // result register: load on accept, drop when taken, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(whps_pkg::M_TDATA_W - whps_pkg::RESULT_BITS){1'b0}}, r_result};

    // lean latch cannot stand without the load latch
    a_lean_needs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warn_on[whps_pkg::W_LEAN] |-> r_load_latched)
        else $error("lean latch set while load latch clear");

    // a fresh result reports the latch states just stored
    a_mask_tracks_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_result.active_mask == r_warn_on))
        else $error("result mask differs from latch state");

    // warning code stays within the defined set
    a_wid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.warning_id == whps_pkg::WID_NONE
            || r_result.warning_id == whps_pkg::WID_FAULT
            || r_result.warning_id == whps_pkg::WID_REV
            || r_result.warning_id == whps_pkg::WID_BOOST
            || r_result.warning_id == whps_pkg::WID_LEAN))
        else $error("warning code out of range");

    // a fault that is on and visible is always the warning selected
    a_fault_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_item.fault_active && w_shows[whps_pkg::W_FAULT])
        |=> (r_result.warning_id == whps_pkg::WID_FAULT))
        else $error("visible fault not selected");

    // a result is not dropped while the master stalls
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result lost");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the dashboard warning selector.
// A queue of update requests feeds a clocked driver; a clocked monitor predicts
// each accepted request and checks every result request against the prediction.
module tb_top;
    import whps_pkg::*;

    // Warning code for each slot, indexed by slot number (fault first)
    localparam logic [NUM_WARN-1:0][WID_W-1:0] SLOT_CODE =
        {WID_LEAN, WID_BOOST, WID_REV, WID_FAULT};

    // Random requests per threshold phase, and the number of threshold phases
    localparam int PHASE_UPDATES = 50;
    localparam int NUM_PHASES    = 8;
    // Cycle limit for one phase to drain before it counts as stuck
    localparam int DRAIN_LIMIT   = 5000;

    typedef enum {
        LEVELS_RANDOM,
        LEVELS_TYPICAL,
        LEVELS_WIDE,
        LEVELS_INVERTED
    } t_level_set;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Stimulus and scoreboard
    t_item   pending_updates[$];
    t_result warn_expect[$];
    logic    req_taken = 1'b0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      fail_count     = 0;
    int      results_seen   = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    t_result got_res;
    t_result want_res;

    // Shadow copy of the thresholds and of the selector state
    logic signed [CFG_W-1:0] thr [NUM_CFG];
    logic [NUM_WARN-1:0]     shadow_on;
    logic                    load_latch;
    logic [TIME_W-1:0]       hold_until [NUM_WARN];

    warning_hysteresis_priority_select_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Next latch state: a stale or missing reading drops the latch; otherwise
    // an active latch holds down to the off level, an idle one needs the on level.
    function automatic logic latch_next(
        input logic                        was,
        input logic                        fresh,
        input logic signed [READING_W-1:0] val,
        input logic signed [CFG_W-1:0]     on_lv,
        input logic signed [CFG_W-1:0]     off_lv
    );
        if (!fresh) return 1'b0;
        return was ? (val >= off_lv) : (val >= on_lv);
    endfunction

    // Advance the shadow state by one update and return the result it causes
    function automatic t_result predict_warning(input t_item upd);
        logic [NUM_WARN-1:0] next_on;
        logic [NUM_WARN-1:0] shown;
        logic [TIME_W-1:0]   since;
        t_result             res;
        int                  s;
        next_on[W_FAULT] = upd.fault_active;
        next_on[W_REV]   = latch_next(shadow_on[W_REV], upd.rpm_ok, upd.rpm_value,
                                      thr[CFG_REV_ON], thr[CFG_REV_OFF]);
        next_on[W_BOOST] = latch_next(shadow_on[W_BOOST], upd.map_ok, upd.map_value,
                                      thr[CFG_BOOST_ON], thr[CFG_BOOST_OFF]);
        // Load updates before lean, and lean sees the new load state
        load_latch       = latch_next(load_latch, upd.map_ok, upd.map_value,
                                      thr[CFG_LOAD_ON], thr[CFG_LOAD_OFF]);
        next_on[W_LEAN]  = load_latch &&
                           latch_next(shadow_on[W_LEAN], upd.afr_ok, upd.afr_value,
                                      thr[CFG_LEAN_ON], thr[CFG_LEAN_OFF]);
        shown = {upd.page_shows_afr, upd.page_shows_map, upd.page_shows_rpm,
                 upd.node_id == SHARED_NODE_ID};
        res.warning_id = WID_NONE;
        for (s = 0; s < NUM_WARN; s++) begin
            // A rising latch arms its hold-over; the sum wraps like the time stamp
            if (next_on[s] && !shadow_on[s]) hold_until[s] = upd.now_ms + HOLD_MS;
            since = upd.now_ms - hold_until[s];
            if (res.warning_id == WID_NONE && (next_on[s] || since[TIME_W-1]) && shown[s])
                res.warning_id = SLOT_CODE[s];
        end
        shadow_on       = next_on;
        res.active_mask = next_on;
        return res;
    endfunction

    function automatic t_item mk_update(
        input logic [TIME_W-1:0]           now,
        input logic [NODE_W-1:0]           node,
        input logic                        fault,
        input logic                        rpm_ok,
        input logic signed [READING_W-1:0] rpm,
        input logic                        map_ok,
        input logic signed [READING_W-1:0] map,
        input logic                        afr_ok,
        input logic signed [READING_W-1:0] afr,
        input logic [2:0]                  pages   // {afr, map, rpm}
    );
        t_item upd;
        upd.now_ms         = now;
        upd.node_id        = node;
        upd.fault_active   = fault;
        upd.rpm_ok         = rpm_ok;
        upd.rpm_value      = rpm;
        upd.map_ok         = map_ok;
        upd.map_value      = map;
        upd.afr_ok         = afr_ok;
        upd.afr_value      = afr;
        upd.page_shows_rpm = pages[0];
        upd.page_shows_map = pages[1];
        upd.page_shows_afr = pages[2];
        return upd;
    endfunction

    // Mostly hug the on and off levels so the latches toggle; sometimes anything
    function automatic logic signed [READING_W-1:0] reading_near(
        input logic signed [CFG_W-1:0] on_lv,
        input logic signed [CFG_W-1:0] off_lv
    );
        int v;
        case ($urandom_range(4))
            0, 1:    v = int'(on_lv) + int'($urandom_range(6)) - 3;
            2, 3:    v = int'(off_lv) + int'($urandom_range(6)) - 3;
            default: v = int'($urandom_range(65535)) - 32768;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[READING_W-1:0];
    endfunction

    function automatic t_item random_update();
        t_item upd;
        int    pick;
        // Advance time mostly within the hold window, sometimes past it,
        // and now and then jump anywhere so every time bit moves
        pick = $urandom_range(99);
        if (pick < 70) clock_ms = clock_ms + $urandom_range(600);
        else if (pick < 90) clock_ms = clock_ms + $urandom_range(2600, 1800);
        else clock_ms = $urandom;
        upd.now_ms       = clock_ms;
        upd.node_id      = ($urandom_range(1) == 0) ? SHARED_NODE_ID
                                                    : NODE_W'($urandom_range(255));
        upd.fault_active = ($urandom_range(99) < 30);
        upd.rpm_ok       = ($urandom_range(99) < 88);
        upd.rpm_value    = reading_near(thr[CFG_REV_ON], thr[CFG_REV_OFF]);
        upd.map_ok       = ($urandom_range(99) < 88);
        upd.map_value    = $urandom_range(1) ? reading_near(thr[CFG_BOOST_ON], thr[CFG_BOOST_OFF])
                                             : reading_near(thr[CFG_LOAD_ON], thr[CFG_LOAD_OFF]);
        upd.afr_ok       = ($urandom_range(99) < 88);
        upd.afr_value    = reading_near(thr[CFG_LEAN_ON], thr[CFG_LEAN_OFF]);
        upd.page_shows_rpm = ($urandom_range(1) == 1);
        upd.page_shows_map = ($urandom_range(1) == 1);
        upd.page_shows_afr = ($urandom_range(1) == 1);
        return upd;
    endfunction

    task automatic log_failure(input string what);
        if (fail_count < 10) $display("mismatch: %s", what);
        fail_count++;
    endtask

    // Write all eight thresholds, one per cycle; only called while idle
    task automatic load_thresholds(input t_level_set levels);
        int                      r;
        logic signed [CFG_W-1:0] v;
        for (r = 0; r < NUM_CFG; r++) begin
            case (levels)
                LEVELS_TYPICAL: begin
                    case (r)
                        CFG_REV_ON:    v = 16'sd6500;
                        CFG_REV_OFF:   v = 16'sd6200;
                        CFG_BOOST_ON:  v = 16'sd2000;
                        CFG_BOOST_OFF: v = 16'sd1900;
                        CFG_LOAD_ON:   v = 16'sd1200;
                        CFG_LOAD_OFF:  v = 16'sd1100;
                        CFG_LEAN_ON:   v = 16'sd1500;
                        default:       v = 16'sd1450;
                    endcase
                end
                // On levels sit at even indexes, off levels at odd ones
                LEVELS_WIDE:     v = (r % 2 == 0) ? 16'sh7FFF : 16'sh8000;
                LEVELS_INVERTED: v = (r % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
                default:         v = CFG_W'($urandom_range(65535));
            endcase
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= r[CFG_IDX_W-1:0];
            i_cfg_data  <= v;
            thr[r] = v;
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Hold off until the driver is empty and every result has come back,
    // then let the result pipe settle
    task automatic await_quiet();
        int guard;
        guard = 0;
        while ((pending_updates.size() != 0 || i_s_tvalid || warn_expect.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
            log_failure($sformatf("%0d results still outstanding", warn_expect.size()));
        repeat (3) @(posedge i_clk);
    endtask

    // Driver: present a new request once the previous one has been taken
    // (or the bus is idle); otherwise hold it steady. Idle cycles carry junk data.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || req_taken) begin
            if (pending_updates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(S_TDATA_W - ITEM_BITS){1'b0}}, pending_updates.pop_front()};
            end else begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= {$urandom, $urandom, $urandom};
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check the result first, then queue the prediction for the
    // request taken on this edge, so a result never meets its own request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_res = o_m_tdata[RESULT_BITS-1:0];
                if (warn_expect.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with nothing expected: %h",
                                          results_seen, got_res));
                end else begin
                    want_res = warn_expect.pop_front();
                    if (got_res.warning_id !== want_res.warning_id ||
                        got_res.active_mask !== want_res.active_mask)
                        log_failure($sformatf(
                            "result %0d: warning_id exp %0d got %0d, active_mask exp %b got %b",
                            results_seen, want_res.warning_id, got_res.warning_id,
                            want_res.active_mask, got_res.active_mask));
                end
                results_seen++;
            end
            req_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready)
                warn_expect.push_back(predict_warning(i_s_tdata[ITEM_BITS-1:0]));
        end
    end

    initial begin : stimulus
        int k;
        int n;
        for (k = 0; k < NUM_CFG; k++) thr[k] = '0;
        for (k = 0; k < NUM_WARN; k++) hold_until[k] = '0;
        shadow_on  = '0;
        load_latch = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the thresholds still at their reset value of 0
        // quiet start: nothing on, nothing held
        pending_updates.push_back(mk_update(32'h0, SHARED_NODE_ID, 1'b0,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000));
        // never-fired warnings count as held while bit 31 of the time is set
        pending_updates.push_back(mk_update(32'h8000_0000, SHARED_NODE_ID, 1'b0,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000));
        pending_updates.push_back(mk_update(32'hFFFF_FFFF, 8'hFF, 1'b0,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b111));
        // fault rises, is held after it drops, and expires at the deadline
        pending_updates.push_back(mk_update(32'd0, SHARED_NODE_ID, 1'b1,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000));
        pending_updates.push_back(mk_update(32'd100, SHARED_NODE_ID, 1'b0,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000));
        pending_updates.push_back(mk_update(32'd2000, SHARED_NODE_ID, 1'b0,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 1'b0, 16'sd0, 3'b000));
        // over-rev on, then a missing rpm clears it while the hold keeps it shown
        pending_updates.push_back(mk_update(32'd2100, 8'd1, 1'b0, 1'b1, 16'sh7FFF,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 3'b001));
        pending_updates.push_back(mk_update(32'd2200, 8'd1, 1'b0, 1'b0, 16'sh7FFF,
                                            1'b0, 16'sd0, 1'b0, 16'sd0, 3'b001));
        // boost and load on at the top of the range, lean stays off at the bottom
        pending_updates.push_back(mk_update(32'd2300, 8'd1, 1'b0, 1'b1, 16'sh8000,
                                            1'b1, 16'sh7FFF, 1'b1, 16'sh8000, 3'b110));
        // missing pressure drops boost and load, so lean cannot come on
        pending_updates.push_back(mk_update(32'd2400, 8'd1, 1'b0, 1'b0, 16'sd0,
                                            1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF, 3'b100));
        // lean rises just before the time wraps, so its deadline wraps too
        pending_updates.push_back(mk_update(32'hFFFF_FF00, 8'd1, 1'b0, 1'b0, 16'sd0,
                                            1'b1, 16'sd0, 1'b1, 16'sd0, 3'b100));
        pending_updates.push_back(mk_update(32'h0000_0100, 8'd1, 1'b0, 1'b0, 16'sd0,
                                            1'b1, 16'sd0, 1'b0, 16'sd0, 3'b100));
        pending_updates.push_back(mk_update(32'h0000_06D0, 8'd1, 1'b0, 1'b0, 16'sd0,
                                            1'b1, 16'sd0, 1'b0, 16'sd0, 3'b100));
        // everything on: priority order fault, rev, boost, lean by visibility
        pending_updates.push_back(mk_update(32'd5000, SHARED_NODE_ID, 1'b1, 1'b1, 16'sh7FFF,
                                            1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, 3'b111));
        pending_updates.push_back(mk_update(32'd5001, 8'd1, 1'b1, 1'b1, 16'sh7FFF,
                                            1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, 3'b111));
        pending_updates.push_back(mk_update(32'd5002, 8'd1, 1'b1, 1'b1, 16'sh7FFF,
                                            1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, 3'b110));
        pending_updates.push_back(mk_update(32'd5003, 8'd1, 1'b1, 1'b1, 16'sh7FFF,
                                            1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, 3'b100));
        await_quiet();

        // Random phases: new thresholds each time, and a full drain between
        // phases so the sender pauses until every result is back
        clock_ms = $urandom;
        for (k = 1; k <= NUM_PHASES; k++) begin
            load_thresholds(t_level_set'(k % 4));
            case ((k / 2) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (n = 0; n < PHASE_UPDATES; n++) pending_updates.push_back(random_update());
            await_quiet();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Safety net against a hung handshake
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/whps_pkg.sv
rtl/core/warning_hysteresis_priority_select_top.sv
verif/tb_top.sv
